FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Types and constants of the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int DATA_W      = 32;
	localparam int STEP_W      = $clog2(DATA_W);

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_CHAR  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_DIV_ZERO  = 3'd3,
		ST_OVERFLOW  = 3'd4,
		ST_EMPTY     = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RD_B,
		S_RD_A,
		S_EXEC,
		S_DIV,
		S_FIX,
		S_PUSH,
		S_TOP,
		S_FINISH
	} state_t;

endpackage

FILE: rtl/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Evaluates reverse Polish integer expressions given one ASCII character per
// transfer, using an operand stack of 32-bit two's complement values.
//
//   Channel  Dir  Payload                                    Transfer on
//   s_axis   in   tdata[7:0] char_code, tlast end_of_expr    tvalid & tready
//   m_axis   out  tdata[31:0] result_value, tuser[2:0] status tvalid & tready
//
// A digit, whitespace or bad character passes S_IDLE and S_DECODE; + - and *
// also pass S_RD_B, S_RD_A, S_EXEC and S_PUSH. Division adds S_DIV, where one
// shared 32-bit adder runs 32 restoring steps, and S_FIX. An ending character
// adds S_TOP to read the stack top and S_FINISH, which waits for a free result register.
// The stack is a single-port-write, single-port-read memory with a registered
// read; reset clears only the state machine, the count, the error and the output valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module postfix_stack_evaluator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic        s_axis_tlast,   // end_of_expr
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] result_value
	output logic [2:0]  m_axis_tuser    // [2:0] status
);
	import pse_pkg::*;

	// Sequencer and stack bookkeeping.
	state_t state_q, state_d, done_state;
	logic [CNT_W-1:0] cnt_q;
	status_t err_q;

	// Current character, latched at the input transfer.
	logic [7:0] ch_q;
	logic last_q;
	op_t op_q, op_dec;

	// Character classes.
	logic is_space, is_digit, is_op, stack_full, too_few;

	// Operand stack memory.
	logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
	logic [DATA_W-1:0] rd_data_q, wr_data;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic wr_en;

	// Arithmetic datapath.
	logic [DATA_W-1:0] a_q, b_q, res_q, quo_q, rem_q, dvs_q;
	logic neg_q;
	logic [STEP_W-1:0] step_q;
	logic [DATA_W-1:0] alu_x, alu_y, mul_lo, mag_a, mag_b, div_shift;
	logic [DATA_W:0] alu_sum;
	logic alu_sub;

	// Result register.
	logic m_valid_q;
	logic [DATA_W-1:0] m_data_q;
	status_t m_status_q;
	logic out_free;
	status_t fin_status;
	logic [DATA_W-1:0] fin_value;

	// ------------------------------------------------------------------
	// Character decode
	// ------------------------------------------------------------------
	always_comb begin
		is_space = ch_q inside {[CH_TAB:CH_CR], CH_SPACE};
		is_digit = ch_q inside {[CH_ZERO:CH_NINE]};
		is_op    = ch_q inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
		case (ch_q)
			CH_PLUS:  op_dec = OP_ADD;
			CH_MINUS: op_dec = OP_SUB;
			CH_STAR:  op_dec = OP_MUL;
			default:  op_dec = OP_DIV;
		endcase
	end

	assign stack_full = (cnt_q == CNT_W'(STACK_DEPTH));
	assign too_few    = (cnt_q < CNT_W'(2));
	assign out_free   = !m_valid_q || m_axis_tready;
	assign done_state = last_q ? S_TOP : S_IDLE;

	// ------------------------------------------------------------------
	// Shared adder: add, subtract and the restoring division step.
	// During division the partial remainder stays below the divisor, so
	// the shifted remainder always fits in 32 bits.
	// ------------------------------------------------------------------
	assign div_shift = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};

	always_comb begin
		if (state_q == S_DIV) begin
			alu_x   = div_shift;
			alu_y   = dvs_q;
			alu_sub = 1'b1;
		end else begin
			alu_x   = a_q;
			alu_y   = b_q;
			alu_sub = (op_q == OP_SUB);
		end
		alu_sum = {1'b0, alu_x} + {1'b0, alu_y ^ {DATA_W{alu_sub}}}
			+ {{DATA_W{1'b0}}, alu_sub};
	end

	assign mul_lo = a_q * b_q;
	assign mag_a  = a_q[DATA_W-1] ? (~a_q + DATA_W'(1)) : a_q;
	assign mag_b  = b_q[DATA_W-1] ? (~b_q + DATA_W'(1)) : b_q;

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) state_d = S_DECODE;
			end
			S_DECODE: begin
				if (err_q == ST_OK && is_op && !too_few) state_d = S_RD_B;
				else state_d = done_state;
			end
			S_RD_B: state_d = S_RD_A;
			S_RD_A: state_d = S_EXEC;
			S_EXEC: begin
				if (op_q != OP_DIV) state_d = S_PUSH;
				else if (b_q == '0) state_d = done_state;
				else state_d = S_DIV;
			end
			S_DIV: begin
				if (step_q == '1) state_d = S_FIX;
			end
			S_FIX:    state_d = S_PUSH;
			S_PUSH:   state_d = done_state;
			S_TOP:    state_d = S_FINISH;
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Control outputs: handshake, stack ports and the final result.
	// The second operand is read first, at the top of the stack.
	// ------------------------------------------------------------------
	always_comb begin
		s_axis_tready = (state_q == S_IDLE);
		wr_en   = 1'b0;
		wr_addr = cnt_q[ADDR_W-1:0];
		wr_data = res_q;
		if (state_q == S_RD_B) rd_addr = ADDR_W'(cnt_q - CNT_W'(2));
		else rd_addr = ADDR_W'(cnt_q - CNT_W'(1));
		case (state_q)
			S_DECODE: begin
				wr_en   = (err_q == ST_OK) && is_digit && !stack_full;
				wr_data = DATA_W'(ch_q - CH_ZERO);
			end
			S_PUSH:  wr_en = 1'b1;
			default: wr_en = 1'b0;
		endcase

		if (err_q != ST_OK) fin_status = err_q;
		else if (cnt_q == '0) fin_status = ST_EMPTY;
		else fin_status = ST_OK;
		fin_value = (fin_status == ST_OK) ? rd_data_q : '0;
	end

	// ------------------------------------------------------------------
	// Stack memory
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (wr_en) stack_mem[wr_addr] <= wr_data;
		rd_data_q <= stack_mem[rd_addr];
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			err_q     <= ST_OK;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// A new result may replace the one leaving in the same cycle.
			if (state_q == S_FINISH && out_free) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
			case (state_q)
				S_DECODE: begin
					if (err_q == ST_OK) begin
						if (is_digit) begin
							if (stack_full) err_q <= ST_OVERFLOW;
							else cnt_q <= cnt_q + CNT_W'(1);
						end else if (is_op) begin
							if (too_few) err_q <= ST_UNDERFLOW;
						end else if (!is_space) begin
							err_q <= ST_BAD_CHAR;
						end
					end
				end
				S_RD_A: cnt_q <= cnt_q - CNT_W'(2);
				S_EXEC: begin
					if (op_q == OP_DIV && b_q == '0) err_q <= ST_DIV_ZERO;
				end
				S_PUSH: cnt_q <= cnt_q + CNT_W'(1);
				S_FINISH: begin
					if (out_free) begin
						cnt_q <= '0;
						err_q <= ST_OK;
					end
				end
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_q   <= s_axis_tdata;
			last_q <= s_axis_tlast;
		end
		case (state_q)
			S_DECODE: op_q <= op_dec;
			S_RD_B:   b_q <= rd_data_q;
			S_RD_A:   a_q <= rd_data_q;
			S_EXEC: begin
				case (op_q)
					OP_MUL:  res_q <= mul_lo;
					default: res_q <= alu_sum[DATA_W-1:0];
				endcase
				quo_q  <= mag_a;
				dvs_q  <= mag_b;
				rem_q  <= '0;
				neg_q  <= a_q[DATA_W-1] ^ b_q[DATA_W-1];
				step_q <= '0;
			end
			S_DIV: begin
				// Carry out of the subtraction means the divisor fits.
				if (alu_sum[DATA_W]) rem_q <= alu_sum[DATA_W-1:0];
				else rem_q <= div_shift;
				quo_q  <= {quo_q[DATA_W-2:0], alu_sum[DATA_W]};
				step_q <= step_q + STEP_W'(1);
			end
			S_FIX: res_q <= neg_q ? (~quo_q + DATA_W'(1)) : quo_q;
			default: ;
		endcase
		if (state_q == S_FINISH && out_free) begin
			m_data_q   <= fin_value;
			m_status_q <= fin_status;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_status_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(STACK_DEPTH), "stack count exceeds depth")
	`ASSERT_NEXT(a_err_freeze, err_q != ST_OK && state_q != S_FINISH, $stable(cnt_q), "stack changed after an error")
	`ASSERT_IMPLIES(a_div_nonzero, state_q == S_DIV, dvs_q != '0, "division started with zero divisor")
	`ASSERT_IMPLIES(a_out_source, $rose(m_axis_tvalid), $past(state_q == S_FINISH), "result appeared outside finish")

endmodule
